FILE: src/qyfr_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants, stage types and helpers for the quaternion yaw frame rotation block
package qyfr_pkg;

   localparam int REQ_W = 192;
   localparam int RSP_W = 144;
   localparam int POS_W = 32;
   localparam int YAW_W = 16;
   localparam int PRD_W = 32;
   localparam int SC_W = 34;
   localparam int ATAN_GUARD = 16;
   localparam int VEC_W = 52;
   localparam int ANG_W = 34;
   localparam int GUARD_BITS = 24;
   localparam int KSHIFT = 31 - GUARD_BITS;
   localparam int PX_W = POS_W + 1;
   localparam int MUL_W = PX_W + 32;
   localparam int ROT_W = MUL_W - KSHIFT;
   localparam int SAT_W = ROT_W - GUARD_BITS;
   localparam int MAX_STAGES = 32;

   localparam logic signed [31:0] KINV_Q31 = 32'sd1304065748;
   localparam logic signed [SC_W-1:0] ONE_Q30 = 34'sh0_4000_0000;
   localparam logic signed [ANG_W-1:0] ANG_PI = 34'sh0_8000_0000;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sh0_4000_0000;
   localparam logic signed [SAT_W-1:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [SAT_W-1:0] SAT_MIN = -34'sh0_8000_0000;

   // atan(2^-i), pi = 2^31
   localparam logic [31:0] ATAN_TAB [MAX_STAGES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [POS_W-1:0] radar_x;
      logic signed [POS_W-1:0] radar_y;
      logic signed [POS_W-1:0] drone_x;
      logic signed [POS_W-1:0] drone_y;
   } pos_side_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
      pos_side_type            side;
   } vec_stage_type;

   typedef struct packed {
      logic signed [ROT_W-1:0] x;
      logic signed [ROT_W-1:0] y;
      logic signed [ANG_W-1:0] theta;
      logic [YAW_W-1:0]        yaw;
      logic signed [POS_W-1:0] drone_x;
      logic signed [POS_W-1:0] drone_y;
   } rot_stage_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[POS_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[POS_W-1:0];
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/qyfr_vec_cell.sv
`timescale 1ns / 1ps
// one vectoring step of the atan2 chain
module qyfr_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_prev,
   input  qyfr_pkg::vec_stage_type stage_prev,
   output logic                    valid_next,
   output qyfr_pkg::vec_stage_type stage_next
);
   import qyfr_pkg::*;

   localparam logic signed [ANG_W-1:0] ATAN_STEP = ANG_W'(ATAN_TAB[STAGE]);

   logic signed [VEC_W-1:0] x_cur;
   logic signed [VEC_W-1:0] y_cur;
   logic signed [VEC_W-1:0] x_sh;
   logic signed [VEC_W-1:0] y_sh;
   vec_stage_type cell_in;
   vec_stage_type cell_ff;
   logic valid_ff;

   always_comb begin
      x_cur = stage_prev.x;
      y_cur = stage_prev.y;
      x_sh = x_cur >>> STAGE;
      y_sh = y_cur >>> STAGE;
      cell_in = stage_prev;
      if (y_cur > 0) begin
         cell_in.x = x_cur + y_sh;
         cell_in.y = y_cur - x_sh;
         cell_in.z = stage_prev.z + ATAN_STEP;
      end else begin
         cell_in.x = x_cur - y_sh;
         cell_in.y = y_cur + x_sh;
         cell_in.z = stage_prev.z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign valid_next = valid_ff;
   assign stage_next = cell_ff;

endmodule

FILE: src/qyfr_rot_cell.sv
`timescale 1ns / 1ps
// one rotation step of the frame rotation chain
module qyfr_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_prev,
   input  qyfr_pkg::rot_stage_type stage_prev,
   output logic                    valid_next,
   output qyfr_pkg::rot_stage_type stage_next
);
   import qyfr_pkg::*;

   localparam logic signed [ANG_W-1:0] ATAN_STEP = ANG_W'(ATAN_TAB[STAGE]);

   logic signed [ROT_W-1:0] x_cur;
   logic signed [ROT_W-1:0] y_cur;
   logic signed [ROT_W-1:0] x_sh;
   logic signed [ROT_W-1:0] y_sh;
   rot_stage_type cell_in;
   rot_stage_type cell_ff;
   logic valid_ff;

   always_comb begin
      x_cur = stage_prev.x;
      y_cur = stage_prev.y;
      x_sh = x_cur >>> STAGE;
      y_sh = y_cur >>> STAGE;
      cell_in = stage_prev;
      if (!stage_prev.theta[ANG_W-1]) begin
         cell_in.x = x_cur - y_sh;
         cell_in.y = y_cur + x_sh;
         cell_in.theta = stage_prev.theta - ATAN_STEP;
      end else begin
         cell_in.x = x_cur + y_sh;
         cell_in.y = y_cur - x_sh;
         cell_in.theta = stage_prev.theta + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign valid_next = valid_ff;
   assign stage_next = cell_ff;

endmodule

FILE: src/quaternion_yaw_frame_rotation.sv
`timescale 1ns / 1ps
// top level: quaternion yaw extraction and body-to-local rotation of a radar target
//
// req channel carries one pose sample per item: quaternion, radar target, vehicle position.
// rsp channel returns one item per sample: yaw binary angle, rotated offset, world position.
// items leave in the order they were taken.
// registers from acceptance to rsp_tvalid, in order:
//   product, sum and quadrant stages, one row of atan2 vectoring cells, yaw and
//   half-turn fold, gain multiply, rounding, one row of rotation cells, rounding
//   with saturation, position add with saturation, output register.
// throughput: one item per cycle unless stalled; each cell stage holds its own item.
// stall: the output register is backed by a one-item skid register; while the skid
//   holds an item the whole pipeline freezes and req_tready is low, otherwise
//   req_tready stays high even while rsp_tready is low.
// reset clears every valid bit, so no item is in flight and rsp_tvalid is low;
//   req_tready is low while reset is high.
module quaternion_yaw_frame_rotation #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // quat_w, quat_x, quat_y, quat_z, radar_x, radar_y, drone_x, drone_y
   input  logic [qyfr_pkg::REQ_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // heading, offset_x, offset_y, world_x, world_y
   output logic [qyfr_pkg::RSP_W-1:0] rsp_tdata
);
   import qyfr_pkg::*;

   logic advance;

   logic signed [YAW_W-1:0] quat_w;
   logic signed [YAW_W-1:0] quat_x;
   logic signed [YAW_W-1:0] quat_y;
   logic signed [YAW_W-1:0] quat_z;
   pos_side_type req_side;

   // product stage
   logic s0_valid_ff;
   logic signed [PRD_W-1:0] p_wz_ff;
   logic signed [PRD_W-1:0] p_xy_ff;
   logic signed [PRD_W-1:0] p_yy_ff;
   logic signed [PRD_W-1:0] p_zz_ff;
   pos_side_type s0_side_ff;

   // sine and cosine terms
   logic s1_valid_ff;
   logic signed [SC_W-1:0] s1_s_in;
   logic signed [SC_W-1:0] s1_c_in;
   logic signed [SC_W-1:0] s1_s_ff;
   logic signed [SC_W-1:0] s1_c_ff;
   pos_side_type s1_side_ff;

   // quadrant fold into the vectoring row
   logic s2_valid_ff;
   vec_stage_type s2_in;
   vec_stage_type s2_ff;
   logic signed [VEC_W-1:0] c_ext;
   logic signed [VEC_W-1:0] s_ext;

   logic vec_valid [CORDIC_STAGES+1];
   vec_stage_type vec_data [CORDIC_STAGES+1];

   // yaw and half-turn fold
   logic s3_valid_ff;
   logic signed [ANG_W-1:0] z_fin;
   logic [31:0] a32;
   logic [32:0] yaw_sum;
   logic signed [ANG_W-1:0] theta_ext;
   logic signed [ANG_W-1:0] s3_theta_in;
   logic signed [PX_W-1:0] s3_px_in;
   logic signed [PX_W-1:0] s3_py_in;
   logic signed [ANG_W-1:0] s3_theta_ff;
   logic signed [PX_W-1:0] s3_px_ff;
   logic signed [PX_W-1:0] s3_py_ff;
   logic [YAW_W-1:0] s3_yaw_ff;
   logic signed [POS_W-1:0] s3_dx_ff;
   logic signed [POS_W-1:0] s3_dy_ff;

   // gain multiply
   logic s4_valid_ff;
   logic signed [MUL_W-1:0] s4_mx_in;
   logic signed [MUL_W-1:0] s4_my_in;
   logic signed [MUL_W-1:0] s4_mx_ff;
   logic signed [MUL_W-1:0] s4_my_ff;
   logic signed [ANG_W-1:0] s4_theta_ff;
   logic [YAW_W-1:0] s4_yaw_ff;
   logic signed [POS_W-1:0] s4_dx_ff;
   logic signed [POS_W-1:0] s4_dy_ff;

   // rounding into the rotation row
   logic s5_valid_ff;
   logic signed [MUL_W-1:0] rnd_x;
   logic signed [MUL_W-1:0] rnd_y;
   rot_stage_type s5_in;
   rot_stage_type s5_ff;

   logic rot_valid [CORDIC_STAGES+1];
   rot_stage_type rot_data [CORDIC_STAGES+1];

   // offset rounding and saturation
   logic s6_valid_ff;
   logic signed [ROT_W-1:0] ox_rnd;
   logic signed [ROT_W-1:0] oy_rnd;
   logic signed [POS_W-1:0] s6_ox_in;
   logic signed [POS_W-1:0] s6_oy_in;
   logic signed [POS_W-1:0] s6_ox_ff;
   logic signed [POS_W-1:0] s6_oy_ff;
   logic [YAW_W-1:0] s6_yaw_ff;
   logic signed [POS_W-1:0] s6_dx_ff;
   logic signed [POS_W-1:0] s6_dy_ff;

   // world position
   logic s7_valid_ff;
   logic signed [POS_W-1:0] wx_in;
   logic signed [POS_W-1:0] wy_in;
   logic [RSP_W-1:0] s7_data_ff;

   // output register and skid
   logic load_new;
   logic out_valid_in;
   logic out_valid_ff;
   logic [RSP_W-1:0] out_data_in;
   logic [RSP_W-1:0] out_data_ff;
   logic skid_valid_in;
   logic skid_valid_ff;
   logic [RSP_W-1:0] skid_data_in;
   logic [RSP_W-1:0] skid_data_ff;

   assign advance = !skid_valid_ff;
   assign req_tready = advance && !reset;

   assign quat_w = req_tdata[15:0];
   assign quat_x = req_tdata[31:16];
   assign quat_y = req_tdata[47:32];
   assign quat_z = req_tdata[63:48];
   assign req_side.radar_x = req_tdata[95:64];
   assign req_side.radar_y = req_tdata[127:96];
   assign req_side.drone_x = req_tdata[159:128];
   assign req_side.drone_y = req_tdata[191:160];

   // valid chain of the front and back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= vec_valid[CORDIC_STAGES];
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= rot_valid[CORDIC_STAGES];
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_comb begin
      s1_s_in = (SC_W'(p_wz_ff) + SC_W'(p_xy_ff)) <<< 1;
      s1_c_in = ONE_Q30 - ((SC_W'(p_yy_ff) + SC_W'(p_zz_ff)) <<< 1);

      c_ext = VEC_W'(s1_c_ff) <<< ATAN_GUARD;
      s_ext = VEC_W'(s1_s_ff) <<< ATAN_GUARD;
      s2_in.side = s1_side_ff;
      s2_in.zero = (s1_s_ff == '0) && (s1_c_ff == '0);
      if (s1_c_ff < 0) begin
         s2_in.x = -c_ext;
         s2_in.y = -s_ext;
         s2_in.z = (s1_s_ff >= 0) ? ANG_PI : -ANG_PI;
      end else begin
         s2_in.x = c_ext;
         s2_in.y = s_ext;
         s2_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_wz_ff <= quat_w * quat_z;
         p_xy_ff <= quat_x * quat_y;
         p_yy_ff <= quat_y * quat_y;
         p_zz_ff <= quat_z * quat_z;
         s0_side_ff <= req_side;
         s1_s_ff <= s1_s_in;
         s1_c_ff <= s1_c_in;
         s1_side_ff <= s0_side_ff;
         s2_ff <= s2_in;
      end
   end

   assign vec_valid[0] = s2_valid_ff;
   assign vec_data[0] = s2_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      qyfr_vec_cell #(
         .STAGE(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_prev(vec_valid[i]),
         .stage_prev(vec_data[i]),
         .valid_next(vec_valid[i+1]),
         .stage_next(vec_data[i+1])
      );
   end

   always_comb begin
      z_fin = vec_data[CORDIC_STAGES].zero ? '0 : vec_data[CORDIC_STAGES].z;
      a32 = z_fin[31:0];
      yaw_sum = {1'b0, a32} + 33'h0_0000_8000;
      theta_ext = ANG_W'(signed'(a32));
      s3_px_in = PX_W'(vec_data[CORDIC_STAGES].side.radar_y);
      s3_py_in = PX_W'(vec_data[CORDIC_STAGES].side.radar_x);
      s3_theta_in = theta_ext;
      if (theta_ext > ANG_HALF_PI) begin
         s3_px_in = -s3_px_in;
         s3_py_in = -s3_py_in;
         s3_theta_in = theta_ext - ANG_PI;
      end else if (theta_ext < -ANG_HALF_PI) begin
         s3_px_in = -s3_px_in;
         s3_py_in = -s3_py_in;
         s3_theta_in = theta_ext + ANG_PI;
      end
   end

   always_comb begin
      s4_mx_in = s3_px_ff * KINV_Q31;
      s4_my_in = s3_py_ff * KINV_Q31;

      rnd_x = s4_mx_ff + (MUL_W'(1) <<< (KSHIFT - 1));
      rnd_y = s4_my_ff + (MUL_W'(1) <<< (KSHIFT - 1));
      s5_in.x = rnd_x[KSHIFT +: ROT_W];
      s5_in.y = rnd_y[KSHIFT +: ROT_W];
      s5_in.theta = s4_theta_ff;
      s5_in.yaw = s4_yaw_ff;
      s5_in.drone_x = s4_dx_ff;
      s5_in.drone_y = s4_dy_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_theta_ff <= s3_theta_in;
         s3_px_ff <= s3_px_in;
         s3_py_ff <= s3_py_in;
         s3_yaw_ff <= yaw_sum[31:16];
         s3_dx_ff <= vec_data[CORDIC_STAGES].side.drone_x;
         s3_dy_ff <= vec_data[CORDIC_STAGES].side.drone_y;
         s4_mx_ff <= s4_mx_in;
         s4_my_ff <= s4_my_in;
         s4_theta_ff <= s3_theta_ff;
         s4_yaw_ff <= s3_yaw_ff;
         s4_dx_ff <= s3_dx_ff;
         s4_dy_ff <= s3_dy_ff;
         s5_ff <= s5_in;
      end
   end

   assign rot_valid[0] = s5_valid_ff;
   assign rot_data[0] = s5_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
      qyfr_rot_cell #(
         .STAGE(i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_prev(rot_valid[i]),
         .stage_prev(rot_data[i]),
         .valid_next(rot_valid[i+1]),
         .stage_next(rot_data[i+1])
      );
   end

   always_comb begin
      ox_rnd = rot_data[CORDIC_STAGES].x + (ROT_W'(1) <<< (GUARD_BITS - 1));
      oy_rnd = rot_data[CORDIC_STAGES].y + (ROT_W'(1) <<< (GUARD_BITS - 1));
      s6_ox_in = sat_pos(ox_rnd[ROT_W-1:GUARD_BITS]);
      s6_oy_in = sat_pos(oy_rnd[ROT_W-1:GUARD_BITS]);
      wx_in = sat_pos(SAT_W'(s6_dx_ff) + SAT_W'(s6_ox_ff));
      wy_in = sat_pos(SAT_W'(s6_dy_ff) + SAT_W'(s6_oy_ff));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_ox_ff <= s6_ox_in;
         s6_oy_ff <= s6_oy_in;
         s6_yaw_ff <= rot_data[CORDIC_STAGES].yaw;
         s6_dx_ff <= rot_data[CORDIC_STAGES].drone_x;
         s6_dy_ff <= rot_data[CORDIC_STAGES].drone_y;
         s7_data_ff <= {wy_in, wx_in, s6_oy_ff, s6_ox_ff, s6_yaw_ff};
      end
   end

   assign load_new = advance && s7_valid_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (rsp_tready || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = load_new;
            out_data_in = s7_data_ff;
         end
      end else if (load_new) begin
         skid_valid_in = 1'b1;
         skid_data_in = s7_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

endmodule
